[hw/rtl/tvbe_pkg.sv]
package tvbe_pkg;

    localparam int unsigned ROUND_COUNT = 64;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [WORD_W-1:0] ROUND_DELTA = 32'h458B_CD42;
    localparam logic [WORD_W-1:0] OFFSET_A    = 32'd11;
    localparam logic [WORD_W-1:0] OFFSET_B    = 32'd20;
    localparam logic [WORD_W-1:0] TWEAK_A     = 32'h0000_0020;
    localparam logic [WORD_W-1:0] TWEAK_B     = 32'h0000_0010;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] plain_first;
        logic [WORD_W-1:0] plain_second;
    } t_plain;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_first;
        logic [WORD_W-1:0] cipher_second;
    } t_cipher;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // data handed from one round cell to the next; sum is this round's sum
    typedef struct packed {
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] sum;
    } t_stage;

    function automatic logic [WORD_W-1:0] mix_word(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb,
        input logic [WORD_W-1:0] offset,
        input logic [WORD_W-1:0] tweak
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        a = (w << 6) + ka;
        b = w + sum + offset;
        c = (w >> 9) + kb;
        return a ^ b ^ c ^ tweak;
    endfunction

endpackage

[hw/rtl/tvbe_round_cell.sv]
module tvbe_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tvbe_pkg::t_stage i_data,
    input  tvbe_pkg::t_key   i_key,
    output logic            o_valid,
    output tvbe_pkg::t_stage o_data
);
    import tvbe_pkg::*;

    // half A: update first word; half B: update second word, advance sum
    logic   r_a_valid;
    t_stage r_a;
    t_stage n_a;
    logic   r_b_valid;
    t_stage r_b;
    t_stage n_b;

    always_comb begin
        n_a     = i_data;
        n_a.w1  = i_data.w1 + mix_word(i_data.w2, i_data.sum, i_key.k0, i_key.k1,
                                       OFFSET_A, TWEAK_A);
        n_b     = r_a;
        n_b.w2  = r_a.w2 + mix_word(r_a.w1, r_a.sum, i_key.k2, i_key.k3,
                                    OFFSET_B, TWEAK_B);
        n_b.sum = r_a.sum + ROUND_DELTA;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

[hw/rtl/tea_variant_block_encrypt_core.sv]
// TEA-style 64-bit block encryptor, fully unrolled round pipeline.
//
// Channels:
//   Command: drive i_plain and pulse i_start. A transaction is taken at any
//   rising edge with i_start high and o_busy low. o_busy is always low, so a
//   new block may be started in every cycle.
//   Result: o_done is high for exactly one cycle with the encrypted block on
//   o_cipher. The receiver cannot stall; results must be taken as they come.
//   Config: i_cfg_valid/o_cfg_ready with i_cfg_index (0..3 = key words 0..3)
//   and i_cfg_data. o_cfg_ready is always high. Write keys only while no
//   block is in flight; blocks use the key registers live.
//
// Throughput: one block per cycle. A block passes through the chain of
// ROUND_COUNT round cells, each taking two register stages (first-word half,
// then second-word half).
//
// Reset (synchronous, active low): clears the key registers to zero and
// drops every in-flight block; nothing started before reset is returned.
module tea_variant_block_encrypt_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    output logic                                     o_busy,
    input  tvbe_pkg::t_plain                         i_plain,
    output logic                                     o_done,
    output tvbe_pkg::t_cipher                        o_cipher,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [tvbe_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [tvbe_pkg::WORD_W-1:0]              i_cfg_data
);
    import tvbe_pkg::*;

    localparam int unsigned LATENCY = 2 * ROUND_COUNT;

    t_key   r_key;
    logic   accept;
    logic   cfg_write;

    // chain links: entry i feeds cell i, entry ROUND_COUNT is the chain end
    logic   link_valid [ROUND_COUNT+1];
    t_stage link_data  [ROUND_COUNT+1];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_KEY0: r_key.k0 <= i_cfg_data;
                CFG_KEY1: r_key.k1 <= i_cfg_data;
                CFG_KEY2: r_key.k2 <= i_cfg_data;
                CFG_KEY3: r_key.k3 <= i_cfg_data;
                default:  r_key    <= r_key;
            endcase
        end
    end

    // first round's sum is one delta
    assign link_valid[0]   = accept;
    assign link_data[0].w1  = i_plain.plain_first;
    assign link_data[0].w2  = i_plain.plain_second;
    assign link_data[0].sum = ROUND_DELTA;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        tvbe_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[g]),
            .i_data  (link_data[g]),
            .i_key   (r_key),
            .o_valid (link_valid[g+1]),
            .o_data  (link_data[g+1])
        );
    end

    // last cell output is registered, drive the result port from it
    assign o_done                 = link_valid[ROUND_COUNT];
    assign o_cipher.cipher_first  = link_data[ROUND_COUNT].w1;
    assign o_cipher.cipher_second = link_data[ROUND_COUNT].w2;

    // a result only ever appears after a matching start
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result without matching start");

    // key word 0 write lands in the key register
    a_key0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && i_cfg_index == CFG_KEY0) |=> (r_key.k0 == $past(i_cfg_data)))
        else $error("key word 0 write lost");

    // a write to key word 3 leaves key word 0 alone
    a_key_isolation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && i_cfg_index == CFG_KEY3) |=> $stable(r_key.k0))
        else $error("key write disturbed another word");

endmodule

[verif/tb_tea_variant_block_encrypt_core.sv]
`timescale 1ns / 100ps

module tb_tea_variant_block_encrypt_core;

    import tvbe_pkg::t_plain;
    import tvbe_pkg::t_cipher;
    import tvbe_pkg::t_key;
    import tvbe_pkg::WORD_W;
    import tvbe_pkg::CFG_IDX_W;
    import tvbe_pkg::CFG_KEY0;
    import tvbe_pkg::CFG_KEY1;
    import tvbe_pkg::CFG_KEY2;
    import tvbe_pkg::CFG_KEY3;

    // cipher constants, kept locally so a wrong package value shows up as a mismatch
    localparam int unsigned       ROUNDS     = 64;
    localparam logic [WORD_W-1:0] DELTA      = 32'h458B_CD42;
    localparam logic [WORD_W-1:0] OFS_FIRST  = 32'd11;
    localparam logic [WORD_W-1:0] OFS_SECOND = 32'd20;
    localparam logic [WORD_W-1:0] TWK_FIRST  = 32'h0000_0020;
    localparam logic [WORD_W-1:0] TWK_SECOND = 32'h0000_0010;

    // tail wait, longer than the pipeline depth, catches stray o_done pulses
    localparam int unsigned TAIL_CYCLES  = 2 * ROUNDS + 32;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_BLOCKS = 235;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the key as written, predicts ciphertext per
    // accepted block, compares results in order.
    // ------------------------------------------------------------------
    class cipher_scoreboard;
        t_key        key;
        t_cipher     owed[$];
        int unsigned errors;

        function new();
            key    = '0;
            errors = 0;
        endfunction

        function void load_word(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                CFG_KEY0: key.k0 = data;
                CFG_KEY1: key.k1 = data;
                CFG_KEY2: key.k2 = data;
                CFG_KEY3: key.k3 = data;
                default: ;
            endcase
        endfunction

        // 64 rounds; the second-word half uses the freshly updated first word
        function t_cipher encrypt(t_plain blk);
            logic [WORD_W-1:0] v0;
            logic [WORD_W-1:0] v1;
            logic [WORD_W-1:0] sum;
            t_cipher           res;
            v0  = blk.plain_first;
            v1  = blk.plain_second;
            sum = '0;
            for (int r = 0; r < ROUNDS; r++) begin
                sum = sum + DELTA;
                v0  = v0 + (((v1 << 6) + key.k0) ^ (v1 + sum + OFS_FIRST)
                           ^ ((v1 >> 9) + key.k1) ^ TWK_FIRST);
                v1  = v1 + (((v0 << 6) + key.k2) ^ (v0 + sum + OFS_SECOND)
                           ^ ((v0 >> 9) + key.k3) ^ TWK_SECOND);
            end
            res.cipher_first  = v0;
            res.cipher_second = v1;
            return res;
        endfunction

        function void note_block(t_plain blk);
            owed.push_back(encrypt(blk));
        endfunction

        function void flag(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            errors++;
            $error("%s: expected %h, got %h", field, want, got);
        endfunction

        function void check_block(t_cipher got);
            t_cipher want;
            if (owed.size() == 0) begin
                errors++;
                $error("o_done with no block in flight: %h %h",
                       got.cipher_first, got.cipher_second);
                return;
            end
            want = owed.pop_front();
            if (got.cipher_first !== want.cipher_first)
                flag("cipher_first", want.cipher_first, got.cipher_first);
            if (got.cipher_second !== want.cipher_second)
                flag("cipher_second", want.cipher_second, got.cipher_second);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_plain               i_plain;
    logic                 o_done;
    t_cipher              o_cipher;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    cipher_scoreboard sb;
    int unsigned      cycle_count = 0;

    // corner plaintexts: all zeros/ones, sign bits, checkerboards, and values
    // straddling the shift boundaries (bit 9 for >>9, top 6 bits for <<6)
    logic [63:0] corners [10] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
        64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000,
        64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA,
        64'h0000_0200_FC00_003F, 64'hFFFF_FE00_0000_01FF
    };

    tea_variant_block_encrypt_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_plain     (i_plain),
        .o_done      (o_done),
        .o_cipher    (o_cipher),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitors: everything sampled at the edge, before the DUT updates
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.load_word(i_cfg_index, i_cfg_data);
            if (i_start && !o_busy)
                sb.note_block(i_plain);
            if (o_done)
                sb.check_block(o_cipher);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // start stays high on return so back-to-back blocks need no re-raise
    task automatic send_block(input t_plain blk);
        i_start <= 1'b1;
        i_plain <= blk;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // valid stays high between consecutive writes; caller-side lowering in write_keys
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // sel bit n writes key word n; sel must be nonzero
    task automatic write_keys(input logic [3:0] sel, input t_key k);
        if (sel[0]) put_reg(CFG_KEY0, k.k0);
        if (sel[1]) put_reg(CFG_KEY1, k.k1);
        if (sel[2]) put_reg(CFG_KEY2, k.k2);
        if (sel[3]) put_reg(CFG_KEY3, k.k3);
        i_cfg_valid <= 1'b0;
    endtask

    // keys are read live by the pipeline, so wait for every block to come out
    task automatic drain_blocks();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    // random blocks; with idling on, alternate 40-block stretches of bursty
    // gaps and back-to-back traffic
    task automatic run_blocks(input int unsigned count, input bit idling);
        t_plain blk;
        for (int n = 0; n < count; n++) begin
            blk.plain_first  = pick_word();
            blk.plain_second = pick_word();
            send_block(blk);
            if (idling && ((n / 40) % 2 == 0) && $urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 17));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_key key_set;
        logic [3:0] sel;

        sb = new();
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_plain     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_KEY0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners under the reset key (all zeros), back to back
        foreach (corners[i]) send_block(corners[i]);
        drain_blocks();

        // corners under the all-ones key, with gaps
        write_keys(4'hF, '1);
        foreach (corners[i]) begin
            send_block(corners[i]);
            pause_sender($urandom_range(1, 17));
        end
        drain_blocks();

        // random phases over a range of keys, including partial key updates
        for (int p = 0; p < PHASES; p++) begin
            key_set = {$urandom(), $urandom(), $urandom(), $urandom()};
            sel     = 4'hF;
            case (p)
                1: begin
                    key_set = '0;
                    sel     = 4'b0101;
                end
                2: sel = 4'b1010;
                3: key_set = '0;
                4: key_set = {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h0000_0001};
                5: sel = 4'b0001;
                6: key_set = {4{32'h8000_0000}};
                default: ;
            endcase
            write_keys(sel, key_set);
            // last phase runs with no sender gaps at all
            run_blocks(PHASE_BLOCKS, p != PHASES - 1);
            drain_blocks();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
